// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, quiet while reset is held
`define NQSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// concurrent check that also holds through reset
`define NQSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- src/nqsc_pkg.sv -----
package nqsc_pkg;

    localparam int SIZE_W = 5;
    localparam int COL_W  = 4;
    localparam int CNT_W  = 24;

    localparam logic [SIZE_W-1:0] DEFAULT_BOARD = 5'd8;
    localparam logic [SIZE_W-1:0] MIN_BOARD     = 5'd4;
    localparam logic [CNT_W-1:0]  MAX_COUNT     = 24'd14772512;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SEARCH,
        ST_ACCUM,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             clr_total;
        logic             start;
        logic             step;
        logic             accum;
        logic             dbl;
        logic             load_out;
        logic [COL_W-1:0] column;
    } t_cmd;

    typedef struct packed {
        logic              col_done;
        logic [SIZE_W-1:0] size;
    } t_status;

endpackage

// ----- src/nqsc_if.sv -----
interface nqsc_in_if;
    import nqsc_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0] first_column;
    logic             whole_board;

    modport source (output valid, output first_column, output whole_board, input ready);
    modport sink (input valid, input first_column, input whole_board, output ready);
endinterface

interface nqsc_out_if;
    import nqsc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] solution_count;

    modport source (output valid, output solution_count, input ready);
    modport sink (input valid, input solution_count, output ready);
endinterface

// ----- src/nqsc_controller.sv -----
module nqsc_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    nqsc_in_if.sink              i_in,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    input  nqsc_pkg::t_status    i_status,
    output nqsc_pkg::t_cmd       o_cmd
);
    import nqsc_pkg::*;

    t_state            r_state, n_state;
    logic              r_whole, n_whole;
    logic [COL_W-1:0]  r_col, n_col;
    logic              r_out_valid, n_out_valid;

    logic [SIZE_W-1:0] w_col_ext;
    logic              w_off_board;
    logic              w_last_col;
    logic              w_middle_odd;
    logic              w_out_free;

    assign w_col_ext    = SIZE_W'(r_col);
    assign w_off_board  = (w_col_ext >= i_status.size);
    assign w_last_col   = (w_col_ext == ((i_status.size - SIZE_W'(1)) >> 1));
    assign w_middle_odd = i_status.size[0] && (w_col_ext == (i_status.size >> 1));
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_whole     <= 1'b0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_whole     <= n_whole;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_whole    = r_whole;
        n_col      = r_col;
        i_in.ready = 1'b0;
        o_cmd      = '0;
        o_cmd.column = r_col;
        o_cmd.dbl    = r_whole && !w_middle_odd;

        case (r_state)
            ST_IDLE: begin
                i_in.ready = i_rst_n;
                if (i_in.valid && i_rst_n) begin
                    n_whole         = i_in.whole_board;
                    n_col           = i_in.whole_board ? '0 : i_in.first_column;
                    o_cmd.clr_total = 1'b1;
                    n_state         = ST_START;
                end
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = w_off_board ? ST_ACCUM : ST_SEARCH;
            end
            ST_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_status.col_done) begin
                    n_state = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                o_cmd.accum = 1'b1;
                if (r_whole && !w_last_col) begin
                    n_col   = r_col + COL_W'(1);
                    n_state = ST_START;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = r_out_valid && !i_out_ready;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

endmodule

// ----- src/nqsc_datapath.sv -----
module nqsc_datapath #(
    parameter int MAX_BOARD = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nqsc_pkg::SIZE_W-1:0] i_cfg_data,
    input  nqsc_pkg::t_cmd              i_cmd,
    output nqsc_pkg::t_status           o_status,
    output logic [nqsc_pkg::CNT_W-1:0]  o_solution_count
);
    import nqsc_pkg::*;

    localparam int ROW_W   = $clog2(MAX_BOARD);
    localparam int CUR_W   = $clog2(MAX_BOARD + 1);
    localparam int DIAG_W  = 2 * MAX_BOARD - 1;
    localparam int SHIFT_W = $clog2(DIAG_W);

    logic [SIZE_W-1:0]    r_board;
    logic [MAX_BOARD-1:0] r_cols;
    logic [DIAG_W-1:0]    r_rise;
    logic [DIAG_W-1:0]    r_fall;
    logic [ROW_W-1:0]     r_stack [MAX_BOARD];
    logic [ROW_W-1:0]     r_row;
    logic [CUR_W-1:0]     r_cur;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_total;
    logic [CNT_W-1:0]     r_out;

    logic [SIZE_W-1:0]    w_size;
    logic [SHIFT_W-1:0]   w_fshift;
    logic [MAX_BOARD-1:0] w_rise_row;
    logic [MAX_BOARD-1:0] w_fall_row;
    logic [MAX_BOARD-1:0] w_avail;
    logic                 w_any;
    logic [ROW_W-1:0]     w_pick;
    logic                 w_last_row;
    logic [ROW_W-1:0]     w_prev;
    logic [ROW_W-1:0]     w_prev_col;
    logic [ROW_W-1:0]     w_start_col;
    logic                 w_place;
    logic                 w_toggle;
    logic [ROW_W-1:0]     w_trow;
    logic [ROW_W-1:0]     w_tcol;

    function automatic logic [SHIFT_W-1:0] fall_idx(
        input logic [SIZE_W-1:0] n,
        input logic [ROW_W-1:0]  row,
        input logic [ROW_W-1:0]  col
    );
        return SHIFT_W'(n) - SHIFT_W'(1) + SHIFT_W'(col) - SHIFT_W'(row);
    endfunction

    // board size clamped into the supported range
    always_comb begin
        if (r_board < MIN_BOARD) begin
            w_size = MIN_BOARD;
        end else if (r_board > SIZE_W'(MAX_BOARD)) begin
            w_size = SIZE_W'(MAX_BOARD);
        end else begin
            w_size = r_board;
        end
    end

    assign w_fshift   = SHIFT_W'(w_size - SIZE_W'(1) - SIZE_W'(r_row));
    assign w_rise_row = MAX_BOARD'(r_rise >> r_row);
    assign w_fall_row = MAX_BOARD'(r_fall >> w_fshift);

    // free squares of the current row at or right of the cursor
    always_comb begin
        for (int i = 0; i < MAX_BOARD; i++) begin
            w_avail[i] = (SIZE_W'(i) < w_size) && (CUR_W'(i) >= r_cur) &&
                         !(r_cols[i] || w_rise_row[i] || w_fall_row[i]);
        end
    end

    always_comb begin
        w_pick = '0;
        for (int i = MAX_BOARD - 1; i >= 0; i--) begin
            if (w_avail[i]) begin
                w_pick = ROW_W'(i);
            end
        end
    end

    assign w_any       = |w_avail;
    assign w_last_row  = (SIZE_W'(r_row) == (w_size - SIZE_W'(1)));
    assign w_prev      = r_row - ROW_W'(1);
    assign w_prev_col  = r_stack[w_prev];
    assign w_start_col = ROW_W'(i_cmd.column);
    assign w_place     = i_cmd.step && w_any && !w_last_row;
    assign w_toggle    = i_cmd.step && (!w_any || !w_last_row);
    assign w_trow      = w_any ? r_row : w_prev;
    assign w_tcol      = w_any ? w_pick : w_prev_col;

    assign o_status.col_done = i_cmd.step && !w_any && (w_prev == '0);
    assign o_status.size     = w_size;
    assign o_solution_count  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board <= DEFAULT_BOARD;
        end else if (i_cfg_we) begin
            r_board <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= '0;
            r_rise  <= '0;
            r_fall  <= '0;
            r_row   <= '0;
            r_cur   <= '0;
            r_count <= '0;
            r_total <= '0;
        end else begin
            if (i_cmd.clr_total) begin
                r_total <= '0;
            end
            if (i_cmd.accum) begin
                r_total <= r_total + (i_cmd.dbl ? {r_count[CNT_W-2:0], 1'b0} : r_count);
            end
            if (i_cmd.start) begin
                r_cols  <= MAX_BOARD'(1) << w_start_col;
                r_rise  <= DIAG_W'(1) << w_start_col;
                r_fall  <= DIAG_W'(1) << fall_idx(w_size, '0, w_start_col);
                r_row   <= ROW_W'(1);
                r_cur   <= '0;
                r_count <= '0;
            end
            if (w_toggle) begin
                r_cols <= r_cols ^ (MAX_BOARD'(1) << w_tcol);
                r_rise <= r_rise ^ (DIAG_W'(1) << (SHIFT_W'(w_trow) + SHIFT_W'(w_tcol)));
                r_fall <= r_fall ^ (DIAG_W'(1) << fall_idx(w_size, w_trow, w_tcol));
            end
            if (i_cmd.step) begin
                if (w_any) begin
                    if (w_last_row) begin
                        r_count <= r_count + CNT_W'(1);
                        r_cur   <= CUR_W'(w_pick) + CUR_W'(1);
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                        r_cur <= '0;
                    end
                end else begin
                    r_row <= w_prev;
                    r_cur <= CUR_W'(w_prev_col) + CUR_W'(1);
                end
            end
        end
    end

    // per-row column stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_stack[0] <= w_start_col;
        end else if (w_place) begin
            r_stack[r_row] <= w_pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= r_total;
        end
    end

endmodule

// ----- src/n_queens_solution_counter.sv -----
// channel   dir  word                          handshake
// i_in      in   first_column[3:0], whole_board  valid/ready
// o_out     out  solution_count[23:0]           valid/ready
// cfg       in   board_dim[4:0]                 i_cfg_we, no wait
//
// one search step per cycle: place a queen, count a full board or backtrack a row
// a single-column word passes through start, its search steps, accumulate and done; a
// whole-board word repeats start, search and accumulate for each left-half column
// (and the middle one on an odd board) before done
// reset is synchronous, active low, board size returns to 8
// a new word is taken while the last result waits on o_out; the search stalls at
// its end only when that result has not been taken
module n_queens_solution_counter #(
    parameter int MAX_BOARD = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nqsc_pkg::SIZE_W-1:0] i_cfg_data,
    nqsc_in_if.sink                     i_in,
    nqsc_out_if.source                  o_out
);
    import nqsc_pkg::*;

    t_cmd             w_cmd;
    t_status          w_status;
    logic             w_out_valid;
    logic [CNT_W-1:0] w_count;

    nqsc_controller u_controller (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    nqsc_datapath #(
        .MAX_BOARD (MAX_BOARD)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_solution_count (w_count)
    );

    assign o_out.valid          = w_out_valid;
    assign o_out.solution_count = w_count;

endmodule

// ----- src/nqsc_checker.sv -----
`include "assert_macros.svh"

module nqsc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [nqsc_pkg::CNT_W-1:0] i_count
);
    import nqsc_pkg::*;

    `NQSC_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_count), "result dropped or changed while stalled")
    `NQSC_ASSERT(a_busy_after_accept, i_in_valid && i_in_ready |=> !i_in_ready, "second word taken while a search is running")
    `NQSC_ASSERT(a_count_range, i_out_valid |-> i_count <= MAX_COUNT, "count beyond the largest board total")
    `NQSC_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !i_out_valid, "result shown right after reset")

endmodule

bind n_queens_solution_counter nqsc_checker u_nqsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_count     (o_out.solution_count)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import nqsc_pkg::*;

    localparam int BOARD_MAX    = 16;
    localparam int RANDOM_ITEMS = 150;

    class queens_count_checker;
        localparam int SIDE = 16;

        logic [SIZE_W-1:0] board_dim;
        bit [SIDE-1:0]     col_busy;
        bit [2*SIDE-2:0]   rise_busy;
        bit [2*SIDE-2:0]   fall_busy;
        bit [COL_W-1:0]    row_stack [SIDE];
        int unsigned       depth;
        bit [CNT_W-1:0]    tally;
        logic [CNT_W-1:0]  counts_due [$];
        int                errors;
        int                matched;

        function new();
            board_dim = DEFAULT_BOARD;
        endfunction

        task report(string what);
            $display("ERROR %0t ns: %s", $time, what);
            errors++;
        endtask

        function bit is_free(int unsigned n, int unsigned row, int unsigned col);
            return !col_busy[col] && !rise_busy[col + row] && !fall_busy[n - 1 + col - row];
        endfunction

        function void flip(int unsigned n, int unsigned row, int unsigned col);
            col_busy[col]              = ~col_busy[col];
            rise_busy[col + row]       = ~rise_busy[col + row];
            fall_busy[n - 1 + col - row] = ~fall_busy[n - 1 + col - row];
        endfunction

        // depth-first walk with the row 0 queen fixed
        function bit [CNT_W-1:0] count_column(int unsigned n, int unsigned first);
            int unsigned c;
            col_busy  = '0;
            rise_busy = '0;
            fall_busy = '0;
            tally     = '0;
            if (first >= n) return '0;
            row_stack[0] = COL_W'(first);
            flip(n, 0, first);
            depth = 1;
            c = 0;
            while (depth != 0) begin
                while (c < n && !is_free(n, depth, c)) c++;
                if (c < n) begin
                    if (depth == n - 1) begin
                        tally = tally + 1'b1;
                        c++;
                    end else begin
                        row_stack[depth] = COL_W'(c);
                        flip(n, depth, c);
                        depth++;
                        c = 0;
                    end
                end else begin
                    depth--;
                    c = row_stack[depth];
                    flip(n, depth, c);
                    c++;
                end
            end
            return tally;
        endfunction

        function logic [CNT_W-1:0] predict_count(logic [COL_W-1:0] first_column,
                                                 logic whole_board);
            int unsigned n;
            logic [CNT_W-1:0] total;
            if (board_dim < MIN_BOARD) n = MIN_BOARD;
            else if (board_dim > SIDE) n = SIDE;
            else n = board_dim;
            total = '0;
            if (whole_board) begin
                // mirror symmetry: left half twice, middle column once
                for (int unsigned c = 0; c < n / 2; c++)
                    total = total + CNT_W'(2 * count_column(n, c));
                if (n % 2 == 1)
                    total = total + count_column(n, n / 2);
            end else begin
                total = count_column(n, first_column);
            end
            return total;
        endfunction

        function void note_request(logic [COL_W-1:0] first_column, logic whole_board);
            counts_due.push_back(predict_count(first_column, whole_board));
        endfunction

        task check_count(logic [CNT_W-1:0] got);
            logic [CNT_W-1:0] want;
            if (counts_due.size() == 0) begin
                report($sformatf("solution count %0d with no request outstanding", got));
            end else begin
                want = counts_due.pop_front();
                if (got !== want)
                    report($sformatf("solution count %0d, expected %0d", got, want));
                else
                    matched++;
            end
        endtask
    endclass

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              cfg_we   = 1'b0;
    logic [SIZE_W-1:0] cfg_data = '0;
    bit                steady;
    int                n_requests;
    int                n_whole;
    int                n_settings;
    queens_count_checker sb;

    nqsc_in_if  in_if ();
    nqsc_out_if out_if ();

    n_queens_solution_counter #(
        .MAX_BOARD(BOARD_MAX)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_if.sink),
        .o_out      (out_if.source)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_if.ready <= steady || ($urandom_range(0, 99) >= 10);
    end

    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready)
            sb.check_count(out_if.solution_count);
    end

    task automatic send_request(input logic [COL_W-1:0] column, input logic whole);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 10) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid        <= 1'b1;
        in_if.first_column <= column;
        in_if.whole_board  <= whole;
        do @(posedge clk); while (!in_if.ready);
        sb.note_request(column, whole);
        n_requests++;
        if (whole) n_whole++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (sb.counts_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_board_dim(input logic [SIZE_W-1:0] value);
        settle();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.board_dim = value;
        n_settings++;
    endtask

    initial begin
        #150_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int               sent;
        int               phase_len;
        logic [SIZE_W-1:0] size;
        bit               wide_done;
        sb = new();
        in_if.valid        = 1'b0;
        in_if.first_column = '0;
        in_if.whole_board  = 1'b0;
        out_if.ready       = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset size of eight
        send_request(4'd0, 1'b1);
        send_request(4'd15, 1'b1);
        send_request(4'd0, 1'b0);
        send_request(4'd7, 1'b0);
        send_request(4'd8, 1'b0);
        send_request(4'd15, 1'b0);
        // below range, treated as four
        write_board_dim(5'd0);
        send_request(4'd0, 1'b1);
        send_request(4'd3, 1'b0);
        send_request(4'd4, 1'b0);
        send_request(4'd15, 1'b0);
        write_board_dim(5'd3);
        send_request(4'd9, 1'b1);
        send_request(4'd1, 1'b0);
        // odd size, middle column counted once
        write_board_dim(5'd5);
        send_request(4'd0, 1'b1);
        send_request(4'd2, 1'b0);
        write_board_dim(5'd4);
        send_request(4'd0, 1'b1);
        write_board_dim(5'd11);
        send_request(4'd5, 1'b0);
        // above range and full size: a search there runs far beyond the cycle budget
        write_board_dim(5'd31);
        write_board_dim(5'd16);

        sent = 0;
        wide_done = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (!wide_done && $urandom_range(0, 7) == 0) begin
                size      = 5'd10;
                phase_len = 6;
                wide_done = 1'b1;
            end else begin
                size      = SIZE_W'($urandom_range(0, 9));
                phase_len = $urandom_range(8, 20);
            end
            write_board_dim(size);
            repeat (phase_len) begin
                steady = (sent >= 50 && sent < 100);
                send_request(COL_W'($urandom_range(0, 15)), $urandom_range(0, 2) == 0);
                sent++;
            end
        end
        steady = 1'b0;

        settle();
        repeat (100) @(posedge clk);
        if (sb.counts_due.size() != 0)
            sb.report($sformatf("%0d expected counts never arrived", sb.counts_due.size()));

        $display("covered %0d requests, %0d of them whole-board, over %0d board-size writes",
                 n_requests, n_whole, n_settings);
        $display("%0d counts matched, %0d mismatches", sb.matched, sb.errors);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/nqsc_pkg.sv
src/nqsc_if.sv
src/nqsc_controller.sv
src/nqsc_datapath.sv
src/n_queens_solution_counter.sv
src/nqsc_checker.sv
dv/tb.sv
